/* src/lpd_pkg.sv */
// ============================================================================
// Length-prefixed deframer package
// Result kind codes, parser phase encoding and header constants shared by
// the deframer.
// ============================================================================
package lpd_pkg;

	// Result kinds as seen on the kind port.
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_INVALID = 2'd2;

	// Header layout: four length bytes, then two type bytes.
	localparam logic [2:0] HDR_LEN_BYTES  = 3'd4;
	localparam logic [2:0] HDR_LAST_INDEX = 3'd5;

	localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65535;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_PAYLOAD = 3'b010,
		PH_ERROR   = 3'b100
	} phase_t;

endpackage

/* src/length_prefixed_deframer.sv */
// ============================================================================
// Length-prefixed deframer
// Splits a byte stream into packets with a six-byte header (32-bit big-endian
// length, 16-bit big-endian type) and emits each payload byte with its type
// and first/last marks; an empty or over-long packet gets a single result.
// ============================================================================
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  ----------------------------
//  in       sink       in_valid / in_ready        in_byte
//  out      source     out_valid / out_ready      kind, frame_type, data_byte,
//                                                 first_byte, last_byte
//  cfg      sink       cfg_wr_en (no wait)        cfg_wr_data -> max_payload
//
//  One byte is taken per clock while in_ready is high and parsed in the cycle
//  it is accepted; a result lands in the single output register on that edge.
//  A request is taken whenever that register is empty or is being emptied, so
//  in_ready falls only while out_ready is low with a result waiting.
//  Reset clears the parser to the header phase and restores max_payload to
//  65535; an over-long header leaves the block dropping bytes until reset.
//
module length_prefixed_deframer
	import lpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] frame_type,
	output logic [7:0]  data_byte,
	output logic        first_byte,
	output logic        last_byte,

	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);

	// Parser state.
	phase_t      phase_q, phase_d;
	logic [2:0]  hdr_cnt_q, hdr_cnt_d;
	logic [31:0] length_q, length_d;
	logic [15:0] type_q, type_d;
	logic [31:0] remaining_q, remaining_d;
	logic        at_first_q, at_first_d;
	logic [31:0] max_payload_q;

	// Output register.
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [15:0] type_out_q;
	logic [7:0]  data_q;
	logic        first_q;
	logic        last_q;

	// Result produced by the byte being accepted.
	logic        res_valid;
	logic [1:0]  res_kind;
	logic [15:0] res_type;
	logic [7:0]  res_data;
	logic        res_first;
	logic        res_last;

	logic        in_fire;

	// The output register can take a new result if it is empty or draining.
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		phase_d     = phase_q;
		hdr_cnt_d   = hdr_cnt_q;
		length_d    = length_q;
		type_d      = type_q;
		remaining_d = remaining_q;
		at_first_d  = at_first_q;
		res_valid   = 1'b0;
		res_kind    = KIND_PAYLOAD;
		res_type    = type_q;
		res_data    = 8'd0;
		res_first   = 1'b0;
		res_last    = 1'b0;

		unique case (phase_q)
			PH_HEADER: begin
				if (hdr_cnt_q < HDR_LEN_BYTES) begin
					length_d = {length_q[23:0], in_byte};
				end else begin
					type_d = {type_q[7:0], in_byte};
				end
				hdr_cnt_d = hdr_cnt_q + 3'd1;
				// On the sixth byte the length is complete and the type
				// takes its low byte from the current input.
				if (hdr_cnt_q == HDR_LAST_INDEX) begin
					hdr_cnt_d = 3'd0;
					res_type  = type_d;
					if (length_q > max_payload_q) begin
						phase_d   = PH_ERROR;
						res_valid = 1'b1;
						res_kind  = KIND_INVALID;
						res_last  = 1'b1;
					end else if (length_q == 32'd0) begin
						res_valid = 1'b1;
						res_kind  = KIND_EMPTY;
						res_first = 1'b1;
						res_last  = 1'b1;
					end else begin
						remaining_d = length_q;
						length_d    = 32'd0;
						at_first_d  = 1'b1;
						phase_d     = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				res_valid   = 1'b1;
				res_kind    = KIND_PAYLOAD;
				res_data    = in_byte;
				res_first   = at_first_q;
				res_last    = (remaining_q <= 32'd1);
				at_first_d  = 1'b0;
				remaining_d = remaining_q - 32'd1;
				if (res_last) begin
					remaining_d = 32'd0;
					at_first_d  = 1'b1;
					phase_d     = PH_HEADER;
				end
			end
			default: begin
				// Error phase: the byte is dropped.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hdr_cnt_q   <= 3'd0;
			length_q    <= 32'd0;
			type_q      <= 16'd0;
			remaining_q <= 32'd0;
			at_first_q  <= 1'b1;
		end else if (in_fire) begin
			phase_q     <= phase_d;
			hdr_cnt_q   <= hdr_cnt_d;
			length_q    <= length_d;
			type_q      <= type_d;
			remaining_q <= remaining_d;
			at_first_q  <= at_first_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RESET;
		end else if (cfg_wr_en) begin
			max_payload_q <= cfg_wr_data;
		end
	end

	// Output valid: set by a new result, cleared once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && res_valid) begin
			kind_q     <= res_kind;
			type_out_q <= res_type;
			data_q     <= res_data;
			first_q    <= res_first;
			last_q     <= res_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign frame_type = type_out_q;
	assign data_byte  = data_q;
	assign first_byte = first_q;
	assign last_byte  = last_q;

`ifndef SYNTHESIS
	// Once in error, the parser never leaves it before reset.
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |=> phase_q == PH_ERROR)
		else $error("deframer left the error phase");

	// A payload phase always has at least one byte still to come.
	a_payload_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> remaining_q != 32'd0)
		else $error("payload phase with no bytes remaining");

	// An invalid-header result is only ever shown once the parser is in error.
	a_invalid_in_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_INVALID |-> phase_q == PH_ERROR)
		else $error("invalid result outside the error phase");

	// The header byte counter only runs during the header phase.
	a_hdr_cnt_phase: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q != 3'd0 |-> phase_q == PH_HEADER)
		else $error("header count set outside the header phase");
`endif

endmodule
